[src/debounced_key_event_queue_assert.svh]
// Assertion macros used by the key event queue datapath.
`ifndef DEBOUNCED_KEY_EVENT_QUEUE_ASSERT_SVH
`define DEBOUNCED_KEY_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define DKEQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key event queue check failed");

// Next-cycle implication, switched off while reset is high.
`define DKEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key event queue check failed");

`endif

[src/dkeq_pkg.sv]
// Shared types, codes and defaults for the debounced key event queue.
`default_nettype none

package dkeq_pkg;

   localparam int DEF_QUEUE_DEPTH = 8;
   localparam int DEF_NUM_BUTTONS = 8;

   localparam int KIND_W     = 2;
   localparam int BTN_W      = 4;
   localparam int ETYPE_W    = 2;
   localparam int MASK_W     = 8;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int ENTRY_W    = BTN_W + ETYPE_W;

   localparam logic [INTERVAL_W-1:0] DEBOUNCE_RESET = 16'd50;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

   localparam logic [ETYPE_W-1:0] TYPE_DOWN  = 2'd0;
   localparam logic [ETYPE_W-1:0] TYPE_UP    = 2'd1;
   localparam logic [ETYPE_W-1:0] TYPE_PRESS = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODIFIER_MASK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE      = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BTN_W-1:0]  button_number;
   } dkeq_req_type;

   typedef struct packed {
      logic [BTN_W-1:0]   event_button;
      logic [ETYPE_W-1:0] event_type;
   } dkeq_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick;
      logic intr;
      logic emit_direct;
      logic push;
      logic pop;
      logic set_idle;
      logic emit_mem;
   } dkeq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic event_ok;
      logic direct_ok;
      logic queue_empty;
      logic out_busy;
   } dkeq_sts_type;

endpackage

`default_nettype wire

[src/dkeq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dkeq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/dkeq_ctrl.sv]
// Controller state machine: decodes accepted words and sequences queue pops.
`default_nettype none

module dkeq_ctrl
   import dkeq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic              rsp_stall,
   input  wire dkeq_sts_type      sts,
   output logic                   req_stall,
   output dkeq_cmd_type           cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   logic state_ff;
   logic state_in;
   logic fire;

   assign req_stall = (state_ff != ST_IDLE) || (sts.out_busy && rsp_stall);
   assign fire      = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               unique case (req_kind)
                  KIND_TICK: begin
                     cmd.tick = 1'b1;
                  end
                  KIND_BUTTON: begin
                     cmd.intr = 1'b1;
                     if (sts.event_ok) begin
                        cmd.emit_direct = sts.direct_ok;
                        cmd.push        = !sts.direct_ok;
                     end
                  end
                  KIND_DONE: begin
                     if (!sts.queue_empty) begin
                        cmd.pop  = 1'b1;
                        state_in = ST_POP;
                     end else begin
                        cmd.set_idle = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            // Read data from the event store is valid in this cycle.
            cmd.emit_mem = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/dkeq_datapath.sv]
// Datapath: settings, debounce timer, button flags, event ring and result register.
`default_nettype none

`include "debounced_key_event_queue_assert.svh"

module dkeq_datapath
   import dkeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dkeq_req_type          req_data,
   input  wire logic                  rsp_stall,
   input  wire logic                  csr_wr,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire dkeq_cmd_type          cmd,
   output dkeq_sts_type               sts,
   output logic                       rsp_valid,
   output dkeq_rsp_type               rsp_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int MOD_N = (NUM_BUTTONS < MASK_W) ? NUM_BUTTONS : MASK_W;

   logic [MASK_W-1:0]      modifier_mask_ff;
   logic [INTERVAL_W-1:0]  debounce_interval_ff;
   logic [INTERVAL_W-1:0]  elapsed_ms_ff;
   logic [NUM_BUTTONS-1:0] pressed_flags_ff;
   logic                   consumer_idle_ff;
   logic [PTR_W-1:0]       head_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   rsp_valid_ff;
   dkeq_rsp_type           rsp_data_ff;

   logic [NUM_BUTTONS-1:0] button_sel;
   logic                   button_ok;
   logic                   was_pressed;
   logic                   is_modifier;
   logic                   queue_full;
   logic                   queue_empty;
   dkeq_rsp_type           new_event;
   logic [SUM_W-1:0]       tail_sum;
   logic [SUM_W-1:0]       tail_wrap;
   logic [PTR_W-1:0]       tail_ptr;
   logic [PTR_W-1:0]       head_next;
   logic [ENTRY_W-1:0]     ram_rd_data;
   logic                   take_event;

   // One-hot decode of the button, which also rejects out-of-range numbers.
   always_comb begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         button_sel[i] = ({2'b00, req_data.button_number} == 6'(i + 1));
      end
   end

   always_comb begin
      is_modifier = 1'b0;
      for (int i = 0; i < MOD_N; i++) begin
         is_modifier = is_modifier | (button_sel[i] & modifier_mask_ff[i]);
      end
   end

   assign button_ok   = |button_sel;
   assign was_pressed = |(button_sel & pressed_flags_ff);
   assign queue_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign queue_empty = (count_ff == '0);

   assign new_event.event_button = req_data.button_number;
   assign new_event.event_type   = is_modifier ? (was_pressed ? TYPE_UP : TYPE_DOWN)
                                               : TYPE_PRESS;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                        : tail_sum;
   assign tail_ptr  = tail_wrap[PTR_W-1:0];
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign take_event = cmd.emit_direct || cmd.push;

   assign sts.event_ok    = button_ok && !queue_full && (elapsed_ms_ff > debounce_interval_ff);
   assign sts.direct_ok   = consumer_idle_ff && queue_empty;
   assign sts.queue_empty = queue_empty;
   assign sts.out_busy    = rsp_valid_ff;

   dkeq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_store (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ptr),
      .wr_data (new_event),
      .rd_en   (cmd.pop),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_mask_ff     <= '0;
         debounce_interval_ff <= DEBOUNCE_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            CSR_MODIFIER_MASK: modifier_mask_ff     <= csr_wdata[MASK_W-1:0];
            CSR_DEBOUNCE:      debounce_interval_ff <= csr_wdata[INTERVAL_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ms_ff    <= '0;
         pressed_flags_ff <= '0;
         consumer_idle_ff <= 1'b1;
         head_ff          <= '0;
         count_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (cmd.intr) begin
            elapsed_ms_ff <= '0;
         end else if (cmd.tick && (elapsed_ms_ff != '1)) begin
            elapsed_ms_ff <= elapsed_ms_ff + 1'b1;
         end
         if (take_event) begin
            pressed_flags_ff <= pressed_flags_ff ^ button_sel;
         end
         if (cmd.emit_direct) begin
            consumer_idle_ff <= 1'b0;
         end else if (cmd.set_idle) begin
            consumer_idle_ff <= 1'b1;
         end
         if (cmd.push) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.pop) begin
            count_ff <= count_ff - 1'b1;
            head_ff  <= head_next;
         end
         rsp_valid_ff <= cmd.emit_direct || cmd.emit_mem || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_direct) begin
         rsp_data_ff <= new_event;
      end else if (cmd.emit_mem) begin
         rsp_data_ff <= ram_rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DKEQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `DKEQ_ASSERT_IMP(a_push_not_full, clock, reset, cmd.push, !queue_full)
   `DKEQ_ASSERT_IMP(a_direct_slot_free, clock, reset, cmd.emit_direct, !(rsp_valid_ff && rsp_stall))
   `DKEQ_ASSERT_IMP(a_pop_slot_empty, clock, reset, cmd.emit_mem, !rsp_valid_ff)
   `DKEQ_ASSERT_NEXT(a_direct_busy, clock, reset, cmd.emit_direct, !consumer_idle_ff && rsp_valid_ff)

endmodule

`default_nettype wire

[src/debounced_key_event_queue.sv]
// Top level of the debounced key event queue: controller, datapath and ports.
// Ticks, interrupts and completes on an empty queue finish when accepted; the next word
// is taken unless a result is held back. A complete that pops the ring stalls the input
// while the registered event store read runs. Results leave via the output register.
// Reset is synchronous and needs no clearing pass; the event store is never read unwritten.
`default_nettype none

module debounced_key_event_queue
   import dkeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int NUM_BUTTONS = DEF_NUM_BUTTONS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input word channel.
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dkeq_req_type          req_data,
   // Result word channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dkeq_rsp_type               rsp_data,
   // Settings write channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dkeq_cmd_type cmd;
   dkeq_sts_type sts;
   logic         csr_wr;

   // Settings are simple registers, so a write is always taken at once.
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // The controller decodes each accepted word and holds off the input side while
   // a popped event is read from the store, or while a finished result word is
   // still held back by the consumer.
   dkeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // The datapath keeps the debounce timer, the toggle flags, the event ring and
   // the output register that separates the two channels.
   dkeq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
